### rtl/core/rtsu_pkg.sv
// rtsu_pkg: sizes, payload structs, codes and the controller/datapath command types
// for the record table sort and search unit. depends on nothing.
package rtsu_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int NAME_BYTES  = 50;

   localparam int POS_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int BI_W       = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int LEN_W      = $clog2(NAME_BYTES + 1);
   localparam int NAME_DEPTH = TABLE_DEPTH * NAME_BYTES;
   localparam int NAME_AW    = $clog2(NAME_DEPTH);

   localparam int KEY_W   = 31;
   localparam int GRADE_W = 16;
   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 4;
   localparam int CMP_W   = 11;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SORT   = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] RES_NEW      = 4'd0;
   localparam logic [STAT_W-1:0] RES_UPDATED  = 4'd1;
   localparam logic [STAT_W-1:0] RES_FULL     = 4'd2;
   localparam logic [STAT_W-1:0] RES_TOOLONG  = 4'd3;
   localparam logic [STAT_W-1:0] RES_FOUND    = 4'd4;
   localparam logic [STAT_W-1:0] RES_NOTFOUND = 4'd5;
   localparam logic [STAT_W-1:0] RES_SORTED   = 4'd6;
   localparam logic [STAT_W-1:0] RES_ENTRY    = 4'd7;
   localparam logic [STAT_W-1:0] RES_BADPOS   = 4'd8;

   // compare operand pair selection
   localparam logic [1:0] AB_MJ = 2'd0;
   localparam logic [1:0] AB_IM = 2'd1;
   localparam logic [1:0] AB_JJ = 2'd2;

   // permutation table read address selection
   localparam logic [1:0] PR_I   = 2'd0;
   localparam logic [1:0] PR_PA  = 2'd1;
   localparam logic [1:0] PR_PB  = 2'd2;
   localparam logic [1:0] PR_POS = 2'd3;

   // permutation table write selection
   localparam logic [1:0] PW_N  = 2'd0;
   localparam logic [1:0] PW_PA = 2'd1;
   localparam logic [1:0] PW_PB = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [KEY_W-1:0]   key;
      logic [GRADE_W-1:0] grade;
      logic [BYTE_W-1:0]  name_byte;
      logic               name_last;
      logic               sort_algorithm;
      logic               order_by;
      logic [5:0]         position;
      logic [5:0]         byte_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [5:0]         found_position;
      logic [CMP_W-1:0]   comparisons;
      logic [KEY_W-1:0]   entry_key;
      logic [GRADE_W-1:0] entry_grade;
      logic [BYTE_W-1:0]  entry_name_byte;
      logic [6:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic              req_load;
      logic              stage_byte;
      logic              stage_clear;
      logic              cmp_clear;
      logic              cmp_bump;
      logic              i_clr;
      logic              i_one;
      logic              i_inc;
      logic              j_from_i;
      logic              j_from_i1;
      logic              j_inc;
      logic              j_dec;
      logic              m_from_i;
      logic              m_from_j;
      logic              ab_load;
      logic [1:0]        ab_sel;
      logic [1:0]        perm_rsel;
      logic              perm_wr;
      logic [1:0]        perm_wsel;
      logic              slota_perm;
      logic              slota_n;
      logic              slotb_perm;
      logic              key_rsel;
      logic              keya_load;
      logic              key_wr;
      logic              grade_wr;
      logic              n_inc;
      logic              bi_clr;
      logic              bi_inc;
      logic              name_rsel;
      logic              name_rmode;
      logic              bytea_load;
      logic              name_wr;
      logic              entry_load;
      logic              out_load;
      logic [STAT_W-1:0] out_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       name_last;
      logic       sort_algorithm;
      logic       order_by;
      logic       ovf;
      logic       i_lt_n;
      logic       i1_lt_n;
      logic       j_lt_n;
      logic       j_zero;
      logic       n_full;
      logic       pos_lt_n;
      logic       key_match;
      logic       key_gt;
      logic       key_ne;
      logic       byte_ne;
      logic       byte_gt;
      logic       byte_zero;
      logic       bi_last;
      logic       out_free;
   } sts_type;

endpackage

### rtl/core/record_table_sort_search_unit.sv
// record_table_sort_search_unit: top level of the record table unit.
// depends on rtsu_pkg, rtsu_ctrl, rtsu_dp (and rtsu_ram through rtsu_dp).
//
// Holds up to 64 records (31-bit key, 16-bit grade, 50-byte zero-padded name)
// in table order, one item at a time. An insert arrives one name byte per item;
// the byte marked last commits the record (update of an existing key, append,
// table full or name too long) and only that item gives a result. Records never
// move in memory: a 64-entry position-to-slot table holds the order, and sort and
// swap only rewrite that table. Every table access goes through memories with one
// write port and one read port, and a registered read. A commit scans the records
// held and then writes the name byte by byte; a search scans records in order; a
// read entry looks up its slot and then the record. A sort compares keys, or names
// byte by byte, and rewrites the table on each swap; by name the cost grows with
// the common prefix. Only one item is in progress; a finished result sits in an
// output register so the next item is taken while it waits, and the unit holds
// before loading a new result until the previous one has been taken. No clearing
// pass after reset: stored records are only ever read below the current record
// count.
module record_table_sort_search_unit (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  rtsu_pkg::req_type req_payload,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtsu_pkg::rsp_type rsp_payload
);

   // command and status between sequencer and datapath
   rtsu_pkg::cmd_type cmd;
   rtsu_pkg::sts_type sts;

   // sequencer: one state per memory access step of each operation
   rtsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: memories, counters, comparators and the result register
   rtsu_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/core/rtsu_ram.sv
// rtsu_ram: generic single write port, single read port ram with registered read.
// no dependencies.
module rtsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rtsu_dp.sv
// rtsu_dp: datapath of the record table unit: record memories, permutation table,
// staging buffer, loop counters and result register. depends on rtsu_pkg, rtsu_ram.
module rtsu_dp (
   input  logic              clock,
   input  logic              reset,
   input  rtsu_pkg::cmd_type cmd,
   output rtsu_pkg::sts_type sts,
   input  rtsu_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtsu_pkg::rsp_type rsp_payload
);

   rtsu_pkg::req_type                      req_ff;
   logic [rtsu_pkg::CNT_W-1:0]             n_ff;
   logic [rtsu_pkg::LEN_W-1:0]             len_ff;
   logic                                   ovf_ff;
   logic [rtsu_pkg::CMP_W-1:0]             cmp_ff;
   logic [rtsu_pkg::CNT_W-1:0]             i_ff;
   logic [rtsu_pkg::CNT_W-1:0]             j_ff;
   logic [rtsu_pkg::POS_W-1:0]             m_ff;
   logic [rtsu_pkg::POS_W-1:0]             pa_ff;
   logic [rtsu_pkg::POS_W-1:0]             pb_ff;
   logic [rtsu_pkg::POS_W-1:0]             slota_ff;
   logic [rtsu_pkg::POS_W-1:0]             slotb_ff;
   logic [rtsu_pkg::KEY_W-1:0]             keya_ff;
   logic [rtsu_pkg::BYTE_W-1:0]            bytea_ff;
   logic [rtsu_pkg::BI_W-1:0]              bi_ff;
   logic                                   ended_ff;
   logic                                   ended_in;
   logic [rtsu_pkg::KEY_W-1:0]             ekey_ff;
   logic [rtsu_pkg::GRADE_W-1:0]           egrade_ff;
   logic [rtsu_pkg::BYTE_W-1:0]            ebyte_ff;
   logic                                   rsp_valid_ff;
   rtsu_pkg::rsp_type                      rsp_ff;
   rtsu_pkg::rsp_type                      rsp_in;

   logic                                   perm_we;
   logic [rtsu_pkg::POS_W-1:0]             perm_wa;
   logic [rtsu_pkg::POS_W-1:0]             perm_wd;
   logic [rtsu_pkg::POS_W-1:0]             perm_ra;
   logic [rtsu_pkg::POS_W-1:0]             perm_q;
   logic [rtsu_pkg::KEY_W-1:0]             key_q;
   logic [rtsu_pkg::GRADE_W-1:0]           grade_q;
   logic [rtsu_pkg::NAME_AW-1:0]           name_wa;
   logic [rtsu_pkg::NAME_AW-1:0]           name_ra;
   logic [rtsu_pkg::BYTE_W-1:0]            name_wd;
   logic [rtsu_pkg::BYTE_W-1:0]            name_q;
   logic                                   stage_we;
   logic [rtsu_pkg::BYTE_W-1:0]            stage_q;
   logic                                   len_full;
   logic                                   bidx_ok;
   logic [rtsu_pkg::BI_W-1:0]              rd_bi;
   logic                                   out_free;

   function automatic logic [rtsu_pkg::NAME_AW-1:0] name_addr(
      input logic [rtsu_pkg::POS_W-1:0] slot,
      input logic [rtsu_pkg::BI_W-1:0]  bi
   );
      name_addr = (rtsu_pkg::NAME_AW)'(slot) * (rtsu_pkg::NAME_AW)'(rtsu_pkg::NAME_BYTES)
                + (rtsu_pkg::NAME_AW)'(bi);
   endfunction

   assign len_full = 32'(len_ff) >= rtsu_pkg::NAME_BYTES;
   assign bidx_ok  = 32'(req_ff.byte_index) < rtsu_pkg::NAME_BYTES;
   assign rd_bi    = bidx_ok ? (rtsu_pkg::BI_W)'(req_ff.byte_index) : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // permutation table: position -> slot
   always_comb begin
      perm_we = cmd.perm_wr;
      case (cmd.perm_wsel)
         rtsu_pkg::PW_PA: begin
            perm_wa = pa_ff;
            perm_wd = slotb_ff;
         end
         rtsu_pkg::PW_PB: begin
            perm_wa = pb_ff;
            perm_wd = slota_ff;
         end
         default: begin
            perm_wa = (rtsu_pkg::POS_W)'(n_ff);
            perm_wd = slota_ff;
         end
      endcase
      case (cmd.perm_rsel)
         rtsu_pkg::PR_PA:  perm_ra = pa_ff;
         rtsu_pkg::PR_PB:  perm_ra = pb_ff;
         rtsu_pkg::PR_POS: perm_ra = (rtsu_pkg::POS_W)'(req_ff.position);
         default:          perm_ra = (rtsu_pkg::POS_W)'(i_ff);
      endcase
   end

   // staged name byte, zero once the name has ended or past the staged length
   always_comb begin
      name_wd = '0;
      if (!ended_ff && (32'(bi_ff) < 32'(len_ff))) begin
         name_wd = stage_q;
      end
      ended_in = ended_ff || (name_wd == '0);
   end

   assign name_wa  = name_addr(slota_ff, bi_ff);
   assign name_ra  = name_addr(cmd.name_rsel ? slotb_ff : slota_ff,
                               cmd.name_rmode ? rd_bi : bi_ff);
   assign stage_we = cmd.stage_byte && !len_full;

   rtsu_ram #(.WIDTH(rtsu_pkg::POS_W), .DEPTH(rtsu_pkg::TABLE_DEPTH)) u_perm (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_wa),
      .wr_data (perm_wd),
      .rd_addr (perm_ra),
      .rd_data (perm_q)
   );

   rtsu_ram #(.WIDTH(rtsu_pkg::KEY_W), .DEPTH(rtsu_pkg::TABLE_DEPTH)) u_keys (
      .clock   (clock),
      .wr_en   (cmd.key_wr),
      .wr_addr (slota_ff),
      .wr_data (req_ff.key),
      .rd_addr (cmd.key_rsel ? slotb_ff : slota_ff),
      .rd_data (key_q)
   );

   rtsu_ram #(.WIDTH(rtsu_pkg::GRADE_W), .DEPTH(rtsu_pkg::TABLE_DEPTH)) u_grades (
      .clock   (clock),
      .wr_en   (cmd.grade_wr),
      .wr_addr (slota_ff),
      .wr_data (req_ff.grade),
      .rd_addr (slota_ff),
      .rd_data (grade_q)
   );

   rtsu_ram #(.WIDTH(rtsu_pkg::BYTE_W), .DEPTH(rtsu_pkg::NAME_DEPTH)) u_names (
      .clock   (clock),
      .wr_en   (cmd.name_wr),
      .wr_addr (name_wa),
      .wr_data (name_wd),
      .rd_addr (name_ra),
      .rd_data (name_q)
   );

   rtsu_ram #(.WIDTH(rtsu_pkg::BYTE_W), .DEPTH(rtsu_pkg::NAME_BYTES)) u_stage (
      .clock   (clock),
      .wr_en   (stage_we),
      .wr_addr ((rtsu_pkg::BI_W)'(len_ff)),
      .wr_data (req_ff.name_byte),
      .rd_addr (bi_ff),
      .rd_data (stage_q)
   );

   // result payload, fields not belonging to the status read as zero
   always_comb begin
      rsp_in                 = '0;
      rsp_in.status          = cmd.out_status;
      rsp_in.entry_count     = 7'(n_ff);
      if (cmd.out_status == rtsu_pkg::RES_FOUND) begin
         rsp_in.found_position = 6'(i_ff);
      end
      if (cmd.out_status == rtsu_pkg::RES_SORTED) begin
         rsp_in.comparisons = cmp_ff;
      end
      if (cmd.out_status == rtsu_pkg::RES_ENTRY) begin
         rsp_in.entry_key       = ekey_ff;
         rsp_in.entry_grade     = egrade_ff;
         rsp_in.entry_name_byte = ebyte_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.stage_byte) begin
            if (len_full) begin
               ovf_ff <= 1'b1;
            end else begin
               len_ff <= len_ff + 1'b1;
            end
         end
         if (cmd.stage_clear) begin
            len_ff <= '0;
            ovf_ff <= 1'b0;
         end
         if (cmd.n_inc) begin
            n_ff <= n_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // loop counters and operand registers
   always_ff @(posedge clock) begin
      if (cmd.req_load)    req_ff   <= req_payload;
      if (cmd.cmp_clear)   cmp_ff   <= '0;
      else if (cmd.cmp_bump && (cmp_ff != '1)) cmp_ff <= cmp_ff + 1'b1;
      if (cmd.i_clr)       i_ff     <= '0;
      else if (cmd.i_one)  i_ff     <= (rtsu_pkg::CNT_W)'(1);
      else if (cmd.i_inc)  i_ff     <= i_ff + 1'b1;
      if (cmd.j_from_i)       j_ff  <= i_ff;
      else if (cmd.j_from_i1) j_ff  <= i_ff + 1'b1;
      else if (cmd.j_inc)     j_ff  <= j_ff + 1'b1;
      else if (cmd.j_dec)     j_ff  <= j_ff - 1'b1;
      if (cmd.m_from_i)       m_ff  <= (rtsu_pkg::POS_W)'(i_ff);
      else if (cmd.m_from_j)  m_ff  <= (rtsu_pkg::POS_W)'(j_ff);
      if (cmd.ab_load) begin
         case (cmd.ab_sel)
            rtsu_pkg::AB_IM: begin
               pa_ff <= (rtsu_pkg::POS_W)'(i_ff);
               pb_ff <= m_ff;
            end
            rtsu_pkg::AB_JJ: begin
               pa_ff <= (rtsu_pkg::POS_W)'(j_ff - 1'b1);
               pb_ff <= (rtsu_pkg::POS_W)'(j_ff);
            end
            default: begin
               pa_ff <= m_ff;
               pb_ff <= (rtsu_pkg::POS_W)'(j_ff);
            end
         endcase
      end
      if (cmd.slota_perm)   slota_ff <= perm_q;
      else if (cmd.slota_n) slota_ff <= (rtsu_pkg::POS_W)'(n_ff);
      if (cmd.slotb_perm)   slotb_ff <= perm_q;
      if (cmd.keya_load)    keya_ff  <= key_q;
      if (cmd.bytea_load)   bytea_ff <= name_q;
      if (cmd.bi_clr) begin
         bi_ff    <= '0;
         ended_ff <= 1'b0;
      end else begin
         if (cmd.name_wr) ended_ff <= ended_in;
         if (cmd.bi_inc)  bi_ff    <= bi_ff + 1'b1;
      end
      if (cmd.entry_load) begin
         ekey_ff   <= key_q;
         egrade_ff <= grade_q;
         ebyte_ff  <= bidx_ok ? name_q : '0;
      end
      if (cmd.out_load) rsp_ff <= rsp_in;
   end

   always_comb begin
      sts                = '0;
      sts.op             = req_ff.op;
      sts.name_last      = req_ff.name_last;
      sts.sort_algorithm = req_ff.sort_algorithm;
      sts.order_by       = req_ff.order_by;
      sts.ovf            = ovf_ff;
      sts.i_lt_n         = i_ff < n_ff;
      sts.i1_lt_n        = ((rtsu_pkg::CNT_W + 1)'(i_ff) + 1'b1)
                           < (rtsu_pkg::CNT_W + 1)'(n_ff);
      sts.j_lt_n         = j_ff < n_ff;
      sts.j_zero         = j_ff == '0;
      sts.n_full         = 32'(n_ff) >= rtsu_pkg::TABLE_DEPTH;
      sts.pos_lt_n       = 32'(req_ff.position) < 32'(n_ff);
      sts.key_match      = key_q == req_ff.key;
      sts.key_gt         = keya_ff > key_q;
      sts.key_ne         = keya_ff != key_q;
      sts.byte_ne        = bytea_ff != name_q;
      sts.byte_gt        = bytea_ff > name_q;
      sts.byte_zero      = bytea_ff == '0;
      sts.bi_last        = 32'(bi_ff) == (rtsu_pkg::NAME_BYTES - 1);
      sts.out_free       = out_free;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(n_ff) <= rtsu_pkg::TABLE_DEPTH)
      else $error("record count beyond table depth");

   a_overflow_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.stage_byte && len_full && !cmd.stage_clear |=> ovf_ff)
      else $error("long name did not raise overflow");

endmodule

### rtl/core/rtsu_ctrl.sv
// rtsu_ctrl: sequencer of the record table unit; drives datapath commands
// from datapath status. depends on rtsu_pkg.
module rtsu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtsu_pkg::sts_type sts,
   output rtsu_pkg::cmd_type cmd
);

   localparam logic [5:0] S_IDLE    = 6'd0;
   localparam logic [5:0] S_DISP    = 6'd1;
   localparam logic [5:0] S_COMMIT  = 6'd2;
   localparam logic [5:0] S_SCAN0   = 6'd3;
   localparam logic [5:0] S_SCAN1   = 6'd4;
   localparam logic [5:0] S_SCAN2   = 6'd5;
   localparam logic [5:0] S_SCAN3   = 6'd6;
   localparam logic [5:0] S_UPD     = 6'd7;
   localparam logic [5:0] S_NEW0    = 6'd8;
   localparam logic [5:0] S_NEW1    = 6'd9;
   localparam logic [5:0] S_NAME0   = 6'd10;
   localparam logic [5:0] S_NAME1   = 6'd11;
   localparam logic [5:0] S_RD0     = 6'd12;
   localparam logic [5:0] S_RD1     = 6'd13;
   localparam logic [5:0] S_RD2     = 6'd14;
   localparam logic [5:0] S_RD3     = 6'd15;
   localparam logic [5:0] S_SEL_OUT = 6'd16;
   localparam logic [5:0] S_SEL_IN  = 6'd17;
   localparam logic [5:0] S_INS_OUT = 6'd18;
   localparam logic [5:0] S_INS_IN  = 6'd19;
   localparam logic [5:0] S_CMP0    = 6'd20;
   localparam logic [5:0] S_CMP1    = 6'd21;
   localparam logic [5:0] S_CMP2    = 6'd22;
   localparam logic [5:0] S_CMP3    = 6'd23;
   localparam logic [5:0] S_CMP4    = 6'd24;
   localparam logic [5:0] S_CMP5    = 6'd25;
   localparam logic [5:0] S_NM0     = 6'd26;
   localparam logic [5:0] S_NM1     = 6'd27;
   localparam logic [5:0] S_NM2     = 6'd28;
   localparam logic [5:0] S_RET     = 6'd29;
   localparam logic [5:0] S_SWP0    = 6'd30;
   localparam logic [5:0] S_SWP1    = 6'd31;
   localparam logic [5:0] S_OUT     = 6'd32;

   // compare callers
   localparam logic [1:0] CL_MIN = 2'd0;
   localparam logic [1:0] CL_CHK = 2'd1;
   localparam logic [1:0] CL_INS = 2'd2;

   logic [5:0]                    state_ff, state_in;
   logic [1:0]                    cl_ff, cl_in;
   logic                          gt_ff, gt_in;
   logic [rtsu_pkg::STAT_W-1:0]   res_ff, res_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cl_in    = cl_ff;
      gt_in    = gt_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.op)
               rtsu_pkg::OP_INSERT: begin
                  cmd.stage_byte = 1'b1;
                  state_in       = sts.name_last ? S_COMMIT : S_IDLE;
               end
               rtsu_pkg::OP_SORT: begin
                  cmd.cmp_clear = 1'b1;
                  if (sts.sort_algorithm) begin
                     cmd.i_one = 1'b1;
                     state_in  = S_INS_OUT;
                  end else begin
                     cmd.i_clr = 1'b1;
                     state_in  = S_SEL_OUT;
                  end
               end
               rtsu_pkg::OP_SEARCH: begin
                  cmd.i_clr = 1'b1;
                  state_in  = S_SCAN0;
               end
               default: begin
                  state_in = S_RD0;
               end
            endcase
         end
         S_COMMIT: begin
            if (sts.ovf) begin
               res_in          = rtsu_pkg::RES_TOOLONG;
               cmd.stage_clear = 1'b1;
               state_in        = S_OUT;
            end else begin
               cmd.i_clr = 1'b1;
               state_in  = S_SCAN0;
            end
         end
         S_SCAN0: begin
            if (sts.i_lt_n) begin
               cmd.perm_rsel = rtsu_pkg::PR_I;
               state_in      = S_SCAN1;
            end else if (sts.op == rtsu_pkg::OP_SEARCH) begin
               res_in   = rtsu_pkg::RES_NOTFOUND;
               state_in = S_OUT;
            end else if (sts.n_full) begin
               res_in          = rtsu_pkg::RES_FULL;
               cmd.stage_clear = 1'b1;
               state_in        = S_OUT;
            end else begin
               state_in = S_NEW0;
            end
         end
         S_SCAN1: begin
            cmd.slota_perm = 1'b1;
            state_in       = S_SCAN2;
         end
         S_SCAN2: begin
            state_in = S_SCAN3;
         end
         S_SCAN3: begin
            if (sts.key_match) begin
               if (sts.op == rtsu_pkg::OP_SEARCH) begin
                  res_in   = rtsu_pkg::RES_FOUND;
                  state_in = S_OUT;
               end else begin
                  state_in = S_UPD;
               end
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_SCAN0;
            end
         end
         S_UPD: begin
            cmd.grade_wr = 1'b1;
            cmd.bi_clr   = 1'b1;
            res_in       = rtsu_pkg::RES_UPDATED;
            state_in     = S_NAME0;
         end
         S_NEW0: begin
            cmd.slota_n = 1'b1;
            state_in    = S_NEW1;
         end
         S_NEW1: begin
            cmd.key_wr    = 1'b1;
            cmd.grade_wr  = 1'b1;
            cmd.perm_wr   = 1'b1;
            cmd.perm_wsel = rtsu_pkg::PW_N;
            cmd.n_inc     = 1'b1;
            cmd.bi_clr    = 1'b1;
            res_in        = rtsu_pkg::RES_NEW;
            state_in      = S_NAME0;
         end
         S_NAME0: begin
            state_in = S_NAME1;
         end
         S_NAME1: begin
            cmd.name_wr = 1'b1;
            if (sts.bi_last) begin
               cmd.stage_clear = 1'b1;
               state_in        = S_OUT;
            end else begin
               cmd.bi_inc = 1'b1;
               state_in   = S_NAME0;
            end
         end
         S_RD0: begin
            if (sts.pos_lt_n) begin
               cmd.perm_rsel = rtsu_pkg::PR_POS;
               state_in      = S_RD1;
            end else begin
               res_in   = rtsu_pkg::RES_BADPOS;
               state_in = S_OUT;
            end
         end
         S_RD1: begin
            cmd.slota_perm = 1'b1;
            state_in       = S_RD2;
         end
         S_RD2: begin
            cmd.name_rmode = 1'b1;
            state_in       = S_RD3;
         end
         S_RD3: begin
            cmd.name_rmode = 1'b1;
            cmd.entry_load = 1'b1;
            res_in         = rtsu_pkg::RES_ENTRY;
            state_in       = S_OUT;
         end
         S_SEL_OUT: begin
            if (sts.i1_lt_n) begin
               cmd.m_from_i  = 1'b1;
               cmd.j_from_i1 = 1'b1;
               state_in      = S_SEL_IN;
            end else begin
               res_in   = rtsu_pkg::RES_SORTED;
               state_in = S_OUT;
            end
         end
         S_SEL_IN: begin
            cmd.ab_load = 1'b1;
            if (sts.j_lt_n) begin
               cmd.ab_sel = rtsu_pkg::AB_MJ;
               cl_in      = CL_MIN;
            end else begin
               cmd.ab_sel = rtsu_pkg::AB_IM;
               cl_in      = CL_CHK;
            end
            state_in = S_CMP0;
         end
         S_INS_OUT: begin
            if (sts.i_lt_n) begin
               cmd.j_from_i = 1'b1;
               state_in     = S_INS_IN;
            end else begin
               res_in   = rtsu_pkg::RES_SORTED;
               state_in = S_OUT;
            end
         end
         S_INS_IN: begin
            if (!sts.j_zero) begin
               cmd.cmp_bump = 1'b1;
               cmd.ab_load  = 1'b1;
               cmd.ab_sel   = rtsu_pkg::AB_JJ;
               cl_in        = CL_INS;
               state_in     = S_CMP0;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_INS_OUT;
            end
         end
         S_CMP0: begin
            cmd.perm_rsel = rtsu_pkg::PR_PA;
            state_in      = S_CMP1;
         end
         S_CMP1: begin
            cmd.slota_perm = 1'b1;
            cmd.perm_rsel  = rtsu_pkg::PR_PB;
            state_in       = S_CMP2;
         end
         S_CMP2: begin
            cmd.slotb_perm = 1'b1;
            if (sts.order_by && (cl_ff != CL_CHK)) begin
               cmd.bi_clr = 1'b1;
               state_in   = S_NM0;
            end else begin
               state_in = S_CMP3;
            end
         end
         S_CMP3: begin
            state_in = S_CMP4;
         end
         S_CMP4: begin
            cmd.keya_load = 1'b1;
            cmd.key_rsel  = 1'b1;
            state_in      = S_CMP5;
         end
         S_CMP5: begin
            gt_in    = (cl_ff == CL_CHK) ? sts.key_ne : sts.key_gt;
            state_in = S_RET;
         end
         S_NM0: begin
            state_in = S_NM1;
         end
         S_NM1: begin
            cmd.bytea_load = 1'b1;
            cmd.name_rsel  = 1'b1;
            state_in       = S_NM2;
         end
         S_NM2: begin
            if (sts.byte_ne) begin
               gt_in    = sts.byte_gt;
               state_in = S_RET;
            end else if (sts.byte_zero || sts.bi_last) begin
               gt_in    = 1'b0;
               state_in = S_RET;
            end else begin
               cmd.bi_inc = 1'b1;
               state_in   = S_NM0;
            end
         end
         S_RET: begin
            case (cl_ff)
               CL_MIN: begin
                  cmd.m_from_j = gt_ff;
                  cmd.cmp_bump = 1'b1;
                  cmd.j_inc    = 1'b1;
                  state_in     = S_SEL_IN;
               end
               CL_CHK: begin
                  if (gt_ff) begin
                     state_in = S_SWP0;
                  end else begin
                     cmd.i_inc = 1'b1;
                     state_in  = S_SEL_OUT;
                  end
               end
               default: begin
                  if (gt_ff) begin
                     state_in = S_SWP0;
                  end else begin
                     cmd.i_inc = 1'b1;
                     state_in  = S_INS_OUT;
                  end
               end
            endcase
         end
         S_SWP0: begin
            cmd.perm_wr   = 1'b1;
            cmd.perm_wsel = rtsu_pkg::PW_PA;
            state_in      = S_SWP1;
         end
         S_SWP1: begin
            cmd.perm_wr   = 1'b1;
            cmd.perm_wsel = rtsu_pkg::PW_PB;
            if (cl_ff == CL_CHK) begin
               cmd.i_inc = 1'b1;
               state_in  = S_SEL_OUT;
            end else begin
               cmd.j_dec = 1'b1;
               state_in  = S_INS_IN;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = res_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cl_ff  <= cl_in;
      gt_ff  <= gt_in;
      res_ff <= res_in;
   end

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over an untaken result");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWP1 |-> $past(state_ff) == S_SWP0)
      else $error("swap second half without first half");

   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DISP)
      else $error("accepted item not dispatched");

endmodule

### verif/testbench.sv
// testbench: self-checking bench for record_table_sort_search_unit.
// depends on rtsu_pkg and the unit's rtl. it predicts every result from its own
// copy of the record table and compares them field by field.
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT    = 20000000;
   localparam int REQ_BITS = $bits(rtsu_pkg::req_type);

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rtsu_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rtsu_pkg::rsp_type rsp_payload;

   record_table_sort_search_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // items waiting to be sent, results still owed by the unit
   rtsu_pkg::req_type pending_items[$];
   rtsu_pkg::rsp_type results_due[$];
   int      errors = 0;
   int      cycle = 0;
   int      n_sent = 0;
   int      n_taken = 0;
   int      hold_left = 0;
   bit      hold_done = 1'b0;

   // predicted table contents, in table order
   logic [rtsu_pkg::KEY_W-1:0]   tbl_key[rtsu_pkg::TABLE_DEPTH];
   logic [rtsu_pkg::GRADE_W-1:0] tbl_grade[rtsu_pkg::TABLE_DEPTH];
   logic [7:0]                   tbl_name[rtsu_pkg::TABLE_DEPTH][rtsu_pkg::NAME_BYTES];
   int                           held = 0;
   logic [7:0]                   stg_name[rtsu_pkg::NAME_BYTES];
   int                           stg_len = 0;
   bit                           stg_ovf = 1'b0;

   // record a orders after record b
   function automatic bit rec_after(int a, int b, bit by_name);
      if (!by_name) return tbl_key[a] > tbl_key[b];
      for (int i = 0; i < rtsu_pkg::NAME_BYTES; i++) begin
         if (tbl_name[a][i] != tbl_name[b][i]) return tbl_name[a][i] > tbl_name[b][i];
         if (tbl_name[a][i] == 8'd0) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic void swap_rec(int a, int b);
      logic [rtsu_pkg::KEY_W-1:0]   k;
      logic [rtsu_pkg::GRADE_W-1:0] g;
      logic [7:0]                   t;
      k = tbl_key[a]; tbl_key[a] = tbl_key[b]; tbl_key[b] = k;
      g = tbl_grade[a]; tbl_grade[a] = tbl_grade[b]; tbl_grade[b] = g;
      for (int i = 0; i < rtsu_pkg::NAME_BYTES; i++) begin
         t = tbl_name[a][i]; tbl_name[a][i] = tbl_name[b][i]; tbl_name[b][i] = t;
      end
   endfunction

   // sort the table, return the saturated comparison count
   function automatic int sort_table(bit insertion, bit by_name);
      int c, m, j;
      c = 0;
      if (!insertion) begin
         for (int i = 0; i + 1 < held; i++) begin
            m = i;
            for (int k = i + 1; k < held; k++) begin
               if (rec_after(m, k, by_name)) m = k;
               if (c < 2047) c++;
            end
            // swap only when the minimum really moved
            if (tbl_key[i] != tbl_key[m]) swap_rec(i, m);
         end
      end else begin
         for (int i = 1; i < held; i++) begin
            j = i;
            while (j > 0) begin
               if (c < 2047) c++;
               if (!rec_after(j - 1, j, by_name)) break;
               swap_rec(j - 1, j);
               j--;
            end
         end
      end
      return c;
   endfunction

   // copy the staged name, zero-padded after its first zero byte
   function automatic void save_name(int slot);
      bit         ended;
      logic [7:0] b;
      ended = 1'b0;
      for (int i = 0; i < rtsu_pkg::NAME_BYTES; i++) begin
         b = (!ended && i < stg_len) ? stg_name[i] : 8'd0;
         if (b == 8'd0) ended = 1'b1;
         tbl_name[slot][i] = b;
      end
   endfunction

   function automatic logic [rtsu_pkg::STAT_W-1:0] commit_record(
      logic [rtsu_pkg::KEY_W-1:0] k, logic [rtsu_pkg::GRADE_W-1:0] g);
      if (stg_ovf) return rtsu_pkg::RES_TOOLONG;
      for (int i = 0; i < held; i++) begin
         if (tbl_key[i] == k) begin
            tbl_grade[i] = g;
            save_name(i);
            return rtsu_pkg::RES_UPDATED;
         end
      end
      if (held >= rtsu_pkg::TABLE_DEPTH) return rtsu_pkg::RES_FULL;
      tbl_key[held] = k;
      tbl_grade[held] = g;
      save_name(held);
      held++;
      return rtsu_pkg::RES_NEW;
   endfunction

   // update the predicted table for one accepted item, queue its result if any
   function automatic void predict_result(rtsu_pkg::req_type r);
      rtsu_pkg::rsp_type e;
      e = '0;
      case (r.op)
         rtsu_pkg::OP_INSERT: begin
            if (stg_len < rtsu_pkg::NAME_BYTES) begin
               stg_name[stg_len] = r.name_byte;
               stg_len++;
            end else stg_ovf = 1'b1;
            if (!r.name_last) return;
            e.status = commit_record(r.key, r.grade);
            stg_len = 0;
            stg_ovf = 1'b0;
         end
         rtsu_pkg::OP_SORT: begin
            e.status = rtsu_pkg::RES_SORTED;
            e.comparisons = rtsu_pkg::CMP_W'(sort_table(r.sort_algorithm, r.order_by));
         end
         rtsu_pkg::OP_SEARCH: begin
            e.status = rtsu_pkg::RES_NOTFOUND;
            for (int i = 0; i < held; i++) begin
               if (tbl_key[i] == r.key) begin
                  e.status = rtsu_pkg::RES_FOUND;
                  e.found_position = 6'(i);
                  break;
               end
            end
         end
         default: begin
            if (r.position < held) begin
               e.status = rtsu_pkg::RES_ENTRY;
               e.entry_key = tbl_key[r.position];
               e.entry_grade = tbl_grade[r.position];
               e.entry_name_byte = (r.byte_index < rtsu_pkg::NAME_BYTES) ?
                                   tbl_name[r.position][r.byte_index] : 8'd0;
            end else e.status = rtsu_pkg::RES_BADPOS;
         end
      endcase
      e.entry_count = 7'(held);
      results_due.push_back(e);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d, want %0d (result %0d)", field, got, want, n_taken);
      errors++;
   endtask

   // idle at random, except in a quiet window
   function automatic bit idle_now();
      if (cycle >= 20000 && cycle < 60000) return 1'b0;
      return $urandom_range(0, 99) < 14;
   endfunction

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // driver: offers items from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_result(req_payload);
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            // one pause mid-run until every owed result has arrived
            if (pending_items.size() == 0 || idle_now() ||
                (n_sent == 700 && results_due.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor: takes results and checks them against the oldest prediction
   always @(posedge clock) begin
      rtsu_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected item", rsp_payload.status, -1);
            end else begin
               e = results_due.pop_front();
               if (rsp_payload.status != e.status)
                  report_mismatch("status", rsp_payload.status, e.status);
               if (rsp_payload.found_position != e.found_position)
                  report_mismatch("found_position", rsp_payload.found_position,
                                  e.found_position);
               if (rsp_payload.comparisons != e.comparisons)
                  report_mismatch("comparisons", rsp_payload.comparisons, e.comparisons);
               if (rsp_payload.entry_key != e.entry_key)
                  report_mismatch("entry_key", rsp_payload.entry_key, e.entry_key);
               if (rsp_payload.entry_grade != e.entry_grade)
                  report_mismatch("entry_grade", rsp_payload.entry_grade, e.entry_grade);
               if (rsp_payload.entry_name_byte != e.entry_name_byte)
                  report_mismatch("entry_name_byte", rsp_payload.entry_name_byte,
                                  e.entry_name_byte);
               if (rsp_payload.entry_count != e.entry_count)
                  report_mismatch("entry_count", rsp_payload.entry_count, e.entry_count);
            end
            n_taken++;
         end
         // one long hold-off so the unit backs up into its input
         if (!hold_done && n_taken == 150) begin
            hold_done = 1'b1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_now();
         end
      end
   end

   // random item with every field scrambled, then shaped by the caller
   function automatic rtsu_pkg::req_type noise_item(logic [1:0] op);
      rtsu_pkg::req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom});
      r.op = op;
      return r;
   endfunction

   // one insert: name bytes in order, each carrying key and grade, the last one marked last
   function automatic void add_record(logic [rtsu_pkg::KEY_W-1:0] k,
                                      logic [rtsu_pkg::GRADE_W-1:0] g,
                                      int len, int style);
      rtsu_pkg::req_type r;
      for (int i = 0; i < len; i++) begin
         r = noise_item(rtsu_pkg::OP_INSERT);
         case (style)
            1: r.name_byte = (i == 0) ? 8'hFF : 8'h01;
            2: r.name_byte = 8'("a" + $urandom_range(0, 1));
            default: r.name_byte = ($urandom_range(0, 99) < 3) ? 8'd0 :
                                   8'($urandom_range(1, 255));
         endcase
         r.name_last = (i == len - 1);
         r.key = k;
         r.grade = g;
         pending_items.push_back(r);
      end
   endfunction

   function automatic void add_simple(logic [1:0] op, logic [rtsu_pkg::KEY_W-1:0] k,
                                      int pos, int bidx, bit algo, bit by_name);
      rtsu_pkg::req_type r;
      r = noise_item(op);
      r.key = k;
      r.position = 6'(pos);
      r.byte_index = 6'(bidx);
      r.sort_algorithm = algo;
      r.order_by = by_name;
      pending_items.push_back(r);
   endfunction

   initial begin
      rtsu_pkg::req_type          r;
      int                         pick;
      logic [rtsu_pkg::KEY_W-1:0] k;

      // directed: empty table, extremes, update, zero byte, every sort flavor
      add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 0, 0, 1'b0, 1'b0);
      add_record('0, '0, 1, 1);
      add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, 1'b1, 1'b1);
      add_record({rtsu_pkg::KEY_W{1'b1}}, '1, 2, 1);
      add_record(31'd5, 16'd7, 3, 2);
      add_record('0, 16'h1234, 2, 2);
      r = noise_item(rtsu_pkg::OP_INSERT); r.name_byte = "q"; r.name_last = 1'b0;
      pending_items.push_back(r);
      r.name_byte = 8'd0; pending_items.push_back(r);
      r.name_byte = "z"; r.name_last = 1'b1; r.key = 31'd9;
      pending_items.push_back(r);
      add_simple(rtsu_pkg::OP_SEARCH, {rtsu_pkg::KEY_W{1'b1}}, 0, 0, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_SEARCH, 31'd1234, 0, 0, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 1, 0, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 3, 1, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 0, rtsu_pkg::NAME_BYTES - 1, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 1, 63, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 63, 0, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, 1'b0, 1'b0);
      add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, 1'b0, 1'b1);
      add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, 1'b1, 1'b0);

      // random: mostly inserts, some long or overflowing names; also sorts, searches, reads
      while (pending_items.size() < 1300) begin
         pick = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) == 0) ? rtsu_pkg::KEY_W'($urandom) :
             rtsu_pkg::KEY_W'($urandom_range(0, 99));
         if (pick < 55) begin
            case ($urandom_range(0, 99)) inside
               [0:84]:  add_record(k, 16'($urandom), $urandom_range(1, 6),
                                   $urandom_range(0, 2) == 0 ? 2 : 0);
               [85:92]: add_record(k, 16'($urandom), rtsu_pkg::NAME_BYTES,
                                   $urandom_range(0, 2));
               default: add_record(k, 16'($urandom),
                                   $urandom_range(rtsu_pkg::NAME_BYTES + 1,
                                                  rtsu_pkg::NAME_BYTES + 3), 0);
            endcase
         end else if (pick < 59) begin
            r = noise_item(rtsu_pkg::OP_INSERT); r.name_last = 1'b0;
            pending_items.push_back(r);
         end else if (pick < 61) begin
            add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, $urandom_range(0, 1),
                       $urandom_range(0, 1));
         end else if (pick < 80) begin
            add_simple(rtsu_pkg::OP_SEARCH, k, 0, 0, 1'b0, 1'b0);
         end else begin
            add_simple(rtsu_pkg::OP_READ, 0, $urandom_range(0, 63),
                       $urandom_range(0, 2) == 0 ? $urandom_range(0, 63) :
                       $urandom_range(0, 5), 1'b0, 1'b0);
         end
      end
      // close with a one-byte insert, a sort and a read so nothing is left half staged
      add_record(31'd3, 16'd3, 1, 0);
      add_simple(rtsu_pkg::OP_SORT, 0, 0, 0, 1'b1, 1'b0);
      add_simple(rtsu_pkg::OP_READ, 0, 0, 0, 1'b0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/rtsu_pkg.sv
rtl/core/rtsu_ram.sv
rtl/core/rtsu_dp.sv
rtl/core/rtsu_ctrl.sv
rtl/core/record_table_sort_search_unit.sv
verif/testbench.sv
